### rtl/fdl_pkg.sv
// shared types, constants and helpers of the fractional delay line
package fdl_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int DELAY_W    = 28;
	localparam int MODE_W     = 2;
	localparam int WORK_W     = 26;
	localparam int IN_TDATA_W = 56;

	localparam logic [MODE_W-1:0] MODE_INT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LIN   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CUBIC = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RESET = MODE_LIN;

	localparam logic signed [WORK_W-1:0] TAP_MAX = 26'sd8388607;
	localparam logic signed [WORK_W-1:0] TAP_MIN = -26'sd8388608;

	// floor(n / 6) as (n * ceil(2^28 / 6)) >> 28, exact for n < 2^25
	localparam int DIV6_N     = 25;
	localparam int DIV6_RW    = 26;
	localparam int DIV6_PW    = DIV6_N + DIV6_RW;
	localparam int DIV6_SHIFT = 28;
	localparam logic [DIV6_RW-1:0] DIV6_RECIP = 26'd44739243;
	localparam logic [WORK_W-1:0]  DIV6_BIAS  = 26'd5;

	localparam logic [2:0] LERP_LAST_LIN   = 3'd0;
	localparam logic [2:0] LERP_LAST_CUBIC = 3'd5;
	localparam logic [1:0] READ_LAST       = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_RWAIT,
		S_DIV,
		S_EDGE,
		S_PREP,
		S_MUL,
		S_ADD,
		S_FINISH
	} fdl_state_t;

	typedef enum logic [2:0] {
		PREP_NONE,
		PREP_LIN,
		PREP_CUBIC,
		PREP_DIV,
		PREP_EDGE
	} prep_op_t;

	typedef enum logic [1:0] {
		OUT_RAW,
		OUT_LIN,
		OUT_CUBIC
	} out_kind_t;

	typedef struct packed {
		logic      capture;
		logic      rd_en;
		logic [1:0] rd_idx;
		logic      cubic_off;
		prep_op_t  prep;
		logic      mul_en;
		logic      add_en;
		logic [1:0] lerp_sel;
		logic      out_load;
		out_kind_t out_kind;
	} fdl_cmd_t;

	typedef struct packed {
		logic d_zero;
		logic out_free;
	} fdl_status_t;

	// de Casteljau order: three lerps, then two, then one
	function automatic logic [1:0] lerp_sel_f(input logic [2:0] cnt);
		logic [1:0] sel;
		unique case (cnt)
			3'd0, 3'd3, 3'd5: sel = 2'd0;
			3'd1, 3'd4:       sel = 2'd1;
			3'd2:             sel = 2'd2;
			default:          sel = 2'd0;
		endcase
		return sel;
	endfunction

endpackage

### rtl/fdl_ram.sv
// generic single write port ram with registered read
module fdl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/fdl_ctrl.sv
// sequencing state machine and mode register of the fractional delay line
module fdl_ctrl
	import fdl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [MODE_W-1:0] cfg_wr_data,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	output fdl_cmd_t          cmd,
	input  fdl_status_t       status
);

	fdl_state_t        state_q, state_d;
	logic [1:0]        rcnt_q;
	logic [2:0]        lcnt_q;
	logic [MODE_W-1:0] mode_q;
	logic [2:0]        lerp_last;

	assign lerp_last = (mode_q == MODE_CUBIC) ? LERP_LAST_CUBIC : LERP_LAST_LIN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rcnt_q  <= '0;
			lcnt_q  <= '0;
			mode_q  <= MODE_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			rcnt_q <= (state_q == S_READ) ? rcnt_q + 2'd1 : 2'd0;
			if (state_q == S_ADD) begin
				lcnt_q <= lcnt_q + 3'd1;
			end else if (state_q != S_MUL) begin
				lcnt_q <= '0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (rcnt_q == READ_LAST) begin
					state_d = S_RWAIT;
				end
			end
			S_RWAIT: begin
				unique case (mode_q)
					MODE_LIN:   state_d = S_PREP;
					MODE_CUBIC: state_d = status.d_zero ? S_DIV : S_PREP;
					default:    state_d = S_FINISH;
				endcase
			end
			S_DIV:  state_d = S_EDGE;
			S_EDGE: state_d = S_MUL;
			S_PREP: state_d = S_MUL;
			S_MUL:  state_d = S_ADD;
			S_ADD: begin
				state_d = (lcnt_q == lerp_last) ? S_FINISH : S_MUL;
			end
			S_FINISH: begin
				if (status.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd           = '0;
		cmd.prep      = PREP_NONE;
		cmd.out_kind  = OUT_RAW;
		cmd.cubic_off = (mode_q == MODE_CUBIC) && !status.d_zero;
		cmd.lerp_sel  = lerp_sel_f(lcnt_q);
		s_axis_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.capture   = s_axis_tvalid;
			end
			S_READ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_idx = rcnt_q;
			end
			S_DIV:  cmd.prep = PREP_DIV;
			S_EDGE: cmd.prep = PREP_EDGE;
			S_PREP: cmd.prep = (mode_q == MODE_LIN) ? PREP_LIN : PREP_CUBIC;
			S_MUL:  cmd.mul_en = 1'b1;
			S_ADD:  cmd.add_en = 1'b1;
			S_FINISH: begin
				cmd.out_load = status.out_free;
				unique case (mode_q)
					MODE_LIN:   cmd.out_kind = OUT_LIN;
					MODE_CUBIC: cmd.out_kind = OUT_CUBIC;
					default:    cmd.out_kind = OUT_RAW;
				endcase
			end
			default: cmd.capture = 1'b0;
		endcase
	end

endmodule

### rtl/fdl_dp.sv
// sample ring, control point registers, shared lerp multiplier and output register
module fdl_dp
	import fdl_pkg::*;
#(
	parameter int RING_DEPTH = 4096,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fdl_cmd_t              cmd,
	output fdl_status_t           status,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [SAMPLE_W-1:0]   m_axis_tdata,
	output logic                  m_axis_tuser
);

	localparam int AW  = $clog2(RING_DEPTH);
	localparam int DIW = DELAY_W - FRAC_BITS;
	localparam int PW  = FRAC_BITS + WORK_W + 2;
	localparam logic [AW:0] FILL_FULL = (AW+1)'(RING_DEPTH);

	logic [SAMPLE_W-1:0] in_sample;
	logic [DELAY_W-1:0]  in_delay;

	logic [AW-1:0]        wp_q, wp_next;
	logic [AW:0]          fill_q;
	logic [FRAC_BITS-1:0] x_q;
	logic [DIW-1:0]       dint_q;

	logic [AW-1:0]       rd_k, rd_addr;
	logic                rd_hit;
	logic                rd_s1;
	logic [1:0]          rd_idx_s1;
	logic                hit_s1;
	logic [SAMPLE_W-1:0] ram_q, rdat;

	logic signed [SAMPLE_W-1:0] r0_q, r1_q, r2_q, r3_q;
	logic signed [WORK_W-1:0]   p0_q, p1_q, p2_q, p3_q;
	logic signed [WORK_W-1:0]   r0w, r1w, r2w;

	logic signed [SAMPLE_W:0]   d20, d31;
	logic signed [WORK_W-1:0]   c1, c2;
	logic                       dneg;
	logic [WORK_W-1:0]          n_wide;
	logic [DIV6_PW-1:0]         divp_s1;
	logic                       dneg_s1;
	logic [WORK_W-1:0]          qmag;
	logic signed [WORK_W-1:0]   q6, eb, bmr, ea;

	logic signed [WORK_W-1:0]   la, lb;
	logic signed [WORK_W:0]     ldiff;
	logic signed [FRAC_BITS:0]  xs;
	logic signed [PW-1:0]       prod_s1;
	logic signed [WORK_W+1:0]   linc, lsum;
	logic signed [WORK_W-1:0]   lres;

	logic                m_valid_q;
	logic [SAMPLE_W-1:0] tap_q, tap_d;
	logic                clip_q, clip_d;

	assign in_sample = s_axis_tdata[SAMPLE_W-1:0];
	assign in_delay  = s_axis_tdata[SAMPLE_W +: DELAY_W];

	// write pointer and fill count, entries past the fill count read as zero
	assign wp_next = wp_q + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			rd_s1  <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd_en;
			if (cmd.capture) begin
				wp_q <= wp_next;
				if (fill_q != FILL_FULL) begin
					fill_q <= fill_q + (AW+1)'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q    <= in_delay[FRAC_BITS-1:0];
			dint_q <= in_delay[DELAY_W-1:FRAC_BITS];
		end
		rd_idx_s1 <= cmd.rd_idx;
		hit_s1    <= rd_hit;
	end

	assign rd_k    = AW'(dint_q) + AW'(cmd.rd_idx) - AW'(cmd.cubic_off);
	assign rd_addr = wp_q - rd_k;
	assign rd_hit  = {1'b0, rd_k} < fill_q;

	fdl_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (cmd.capture),
		.wr_addr (wp_next),
		.wr_data (in_sample),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_q)
	);

	assign rdat = hit_s1 ? ram_q : '0;

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			case (rd_idx_s1)
				2'd0:    r0_q <= rdat;
				2'd1:    r1_q <= rdat;
				2'd2:    r2_q <= rdat;
				default: r3_q <= rdat;
			endcase
		end
	end

	// control points
	assign r0w = WORK_W'(r0_q);
	assign r1w = WORK_W'(r1_q);
	assign r2w = WORK_W'(r2_q);

	assign d20 = (SAMPLE_W+1)'(r2_q) - (SAMPLE_W+1)'(r0_q);
	assign d31 = (SAMPLE_W+1)'(r3_q) - (SAMPLE_W+1)'(r1_q);
	assign c1  = r1w + WORK_W'(d20 >>> 2);
	assign c2  = r2w - WORK_W'(d31 >>> 2);

	// edge form: floor division by six, on the magnitude biased up when negative, then sign restored
	assign dneg   = d20[SAMPLE_W];
	assign n_wide = dneg ? (DIV6_BIAS - WORK_W'(d20)) : WORK_W'(d20);

	always_ff @(posedge clk) begin
		if (cmd.prep == PREP_DIV) begin
			divp_s1 <= DIV6_PW'(n_wide[DIV6_N-1:0]) * DIV6_PW'(DIV6_RECIP);
			dneg_s1 <= dneg;
		end
	end

	assign qmag = WORK_W'(divp_s1[DIV6_PW-1:DIV6_SHIFT]);
	assign q6   = dneg_s1 ? (WORK_W'(0) - qmag) : qmag;
	assign eb   = r1w - q6;
	assign bmr  = eb - r0w;
	assign ea   = r0w + (bmr >>> 1);

	// shared lerp: a + floor(x * (b - a) / 2^FRAC_BITS)
	always_comb begin
		case (cmd.lerp_sel)
			2'd0: begin
				la = p0_q;
				lb = p1_q;
			end
			2'd1: begin
				la = p1_q;
				lb = p2_q;
			end
			default: begin
				la = p2_q;
				lb = p3_q;
			end
		endcase
	end

	assign ldiff = (WORK_W+1)'(lb) - (WORK_W+1)'(la);
	assign xs    = {1'b0, x_q};

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= PW'(xs) * PW'(ldiff);
		end
	end

	assign linc = prod_s1[PW-1:FRAC_BITS];
	assign lsum = (WORK_W+2)'(la) + linc;
	assign lres = lsum[WORK_W-1:0];

	always_ff @(posedge clk) begin
		case (cmd.prep)
			PREP_LIN: begin
				p0_q <= r0w;
				p1_q <= r1w;
			end
			PREP_CUBIC: begin
				p0_q <= r1w;
				p1_q <= c1;
				p2_q <= c2;
				p3_q <= r2w;
			end
			PREP_EDGE: begin
				p0_q <= r0w;
				p1_q <= ea;
				p2_q <= eb;
				p3_q <= r1w;
			end
			default: begin
				if (cmd.add_en) begin
					case (cmd.lerp_sel)
						2'd0:    p0_q <= lres;
						2'd1:    p1_q <= lres;
						default: p2_q <= lres;
					endcase
				end
			end
		endcase
	end

	// result selection and saturation
	always_comb begin
		tap_d  = r0_q;
		clip_d = 1'b0;
		case (cmd.out_kind)
			OUT_LIN: tap_d = p0_q[SAMPLE_W-1:0];
			OUT_CUBIC: begin
				if (p0_q > TAP_MAX) begin
					tap_d  = TAP_MAX[SAMPLE_W-1:0];
					clip_d = 1'b1;
				end else if (p0_q < TAP_MIN) begin
					tap_d  = TAP_MIN[SAMPLE_W-1:0];
					clip_d = 1'b1;
				end else begin
					tap_d = p0_q[SAMPLE_W-1:0];
				end
			end
			default: tap_d = r0_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			tap_q  <= tap_d;
			clip_q <= clip_d;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = tap_q;
	assign m_axis_tuser    = clip_q;
	assign status.out_free = !m_valid_q || m_axis_tready;
	assign status.d_zero   = (dint_q == '0);

endmodule

### rtl/fractional_delay_line_top.sv
// top level of the fractional delay line with integer, linear and cubic taps
//
// channel   direction  handshake                      content
// s_axis    in         s_axis_tvalid / s_axis_tready  sample_in, delay
// m_axis    out        m_axis_tvalid / m_axis_tready  tap_out, clipped flag
// cfg       in         cfg_wr_en                      interp_mode
//
// one request at a time; the time from acceptance to the next acceptance rises from
// integer mode through linear and cubic mode to the cubic edge form (integer delay
// zero), set by four ring reads through the one read port and the single shared
// lerp multiplier (a multiply state and an add state per lerp)
// a finished tap waits in the output register while the next request is taken;
// a stalled output holds the sequencer only when it has a new tap to load
// reset needs no clearing pass: a fill count makes never-written ring entries
// read as zero, and interp_mode resets to linear
module fractional_delay_line_top
	import fdl_pkg::*;
#(
	parameter int RING_DEPTH = 4096,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// interp_mode register
	input  logic                  cfg_wr_en,
	input  logic [MODE_W-1:0]     cfg_wr_data,
	// input requests
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // sample_in [23:0], delay [51:24], zero pad
	// tap results
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [SAMPLE_W-1:0]   m_axis_tdata,  // tap_out [23:0]
	output logic                  m_axis_tuser   // clipped
);

	fdl_cmd_t    cmd;
	fdl_status_t status;

	// sequencer: read burst, control point setup, lerp passes, output load
	fdl_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.cmd           (cmd),
		.status        (status)
	);

	// ring memory, arithmetic and output register
	fdl_dp #(
		.RING_DEPTH (RING_DEPTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

### rtl/fdl_checker.sv
// port level checks of the fractional delay line and their binding
module fdl_checker
	import fdl_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [SAMPLE_W-1:0]   m_axis_tdata,
	input logic                  m_axis_tuser
);

	// a clipped tap sits exactly at one of the rails
	a_clip_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			(m_axis_tdata == 24'h7FFFFF || m_axis_tdata == 24'h800000))
		else $error("clipped tap not at a rail");

	// one request in flight: no acceptance right after an acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while another is in work");

	// no result can appear the cycle after a request is taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result too early after request");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind fractional_delay_line_top fdl_checker u_checker (.*);

### bench/fractional_delay_line_top_tb.sv
// self-checking bench for the fractional delay line: stream driver, tap predictor and monitor
`timescale 1ns / 100ps

module fractional_delay_line_top_tb;
	import fdl_pkg::*;

	localparam int RING_DEPTH     = 4096;
	localparam int FRAC_BITS      = 16;
	localparam int IDLE_PCT       = 38;    // chance in a hundred that a side idles
	localparam int HOLD_LEN       = 300;   // long output hold-off, in cycles
	localparam int SETTLE_CYCLES  = 32;    // longer than the slowest request
	localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles, several times the hold-off
	localparam int SAMPLE_MAX     = 8388607;
	localparam int SAMPLE_MIN     = -8388608;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic [DELAY_W-1:0]         delay;
	} tap_request_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] tap;
		logic                       clip;
	} tap_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [MODE_W-1:0]     cfg_wr_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [SAMPLE_W-1:0]   m_axis_tdata;
	logic                  m_axis_tuser;

	// requests waiting for the driver, taps waiting for the monitor
	tap_request_t pending_q[$];
	tap_result_t  tap_expect_q[$];
	tap_request_t drv_req;
	tap_result_t  got_tap;

	// shadow of the block state
	logic signed [SAMPLE_W-1:0] ring_model [RING_DEPTH];
	logic [11:0]                wr_ptr_model;
	logic [MODE_W-1:0]          mode_model;

	// run control shared between the stimulus and the clocked processes
	logic calm = 1'b0;
	int   hold_req = 0;
	int   hold_ack;
	int   hold_left;
	int   quiet_cycles;

	int item_cnt = 0;
	int result_cnt = 0;
	int clip_cnt = 0;
	int err_cnt = 0;

	fractional_delay_line_top #(
		.RING_DEPTH(RING_DEPTH),
		.FRAC_BITS (FRAC_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// ring entry k samples behind the write pointer
	function automatic longint ring_back(int unsigned k);
		logic [11:0] idx;
		idx = wr_ptr_model - k[11:0];
		return ring_model[idx];
	endfunction

	// a + floor(x * (b - a)), x in units of 2^-FRAC_BITS
	function automatic longint lerp_q(longint x, longint a, longint b);
		return a + ((x * (b - a)) >>> FRAC_BITS);
	endfunction

	function automatic longint floor_div6(longint v);
		longint q;
		q = v / 6;
		if (v % 6 != 0 && v < 0)
			q = q - 1;
		return q;
	endfunction

	// de Casteljau: three, two, then one lerp
	function automatic longint bezier_q(longint x, longint p1, longint c1, longint c2,
	                                    longint p2);
		longint l0, l1, l2;
		l0 = lerp_q(x, p1, c1);
		l1 = lerp_q(x, c1, c2);
		l2 = lerp_q(x, c2, p2);
		l0 = lerp_q(x, l0, l1);
		l1 = lerp_q(x, l1, l2);
		return lerp_q(x, l0, l1);
	endfunction

	// store the sample, then read the tap at the requested delay
	function automatic tap_result_t predict_tap(logic signed [SAMPLE_W-1:0] smp,
	                                            logic [DELAY_W-1:0] dly);
		int unsigned d;
		longint      x, y0, y1, y2, y3, c1, c2, v;
		tap_result_t r;
		d = dly[DELAY_W-1:FRAC_BITS];
		x = dly[FRAC_BITS-1:0];
		wr_ptr_model = wr_ptr_model + 12'd1;
		ring_model[wr_ptr_model] = smp;
		r.clip = 1'b0;
		case (mode_model)
			MODE_LIN: v = lerp_q(x, ring_back(d), ring_back(d + 1));
			MODE_CUBIC: begin
				if (d != 0) begin
					y0 = ring_back(d - 1);
					y1 = ring_back(d);
					y2 = ring_back(d + 1);
					y3 = ring_back(d + 2);
					c1 = y1 + ((y2 - y0) >>> 2);
					c2 = y2 - ((y3 - y1) >>> 2);
					v = bezier_q(x, y1, c1, c2, y2);
				end else begin
					// edge form from the three newest samples
					y0 = ring_back(0);
					y1 = ring_back(1);
					y2 = ring_back(2);
					c2 = y1 - floor_div6(y2 - y0);
					c1 = y0 + ((c2 - y0) >>> 1);
					v = bezier_q(x, y0, c1, c2, y1);
				end
				if (v > SAMPLE_MAX) begin
					v = SAMPLE_MAX;
					r.clip = 1'b1;
				end else if (v < SAMPLE_MIN) begin
					v = SAMPLE_MIN;
					r.clip = 1'b1;
				end
			end
			// integer delay, unused mode too
			default: v = ring_back(d);
		endcase
		r.tap = v[SAMPLE_W-1:0];
		return r;
	endfunction

	// ---------------------------------------------------------------- driver

	// next request when the bus is free, idling at random unless calm
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				drv_req = pending_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {4'b0, drv_req.delay, drv_req.sample};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output ready: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_ack      <= 0;
			hold_left     <= 0;
		end else if (hold_ack != hold_req) begin
			hold_ack      <= hold_req;
			hold_left     <= HOLD_LEN;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// ---------------------------------------------------------------- monitor

	task automatic report_error(string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%s", msg);
	endtask

	// taps are checked against the oldest prediction, then new requests predicted
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				result_cnt++;
				if (m_axis_tuser)
					clip_cnt++;
				if (tap_expect_q.size() == 0) begin
					report_error($sformatf("unexpected tap %0d clipped %0b at result %0d",
					                       $signed(m_axis_tdata), m_axis_tuser, result_cnt));
				end else begin
					got_tap = tap_expect_q.pop_front();
					if (m_axis_tdata !== got_tap.tap || m_axis_tuser !== got_tap.clip)
						report_error($sformatf(
							"tap mismatch at result %0d: expected %0d clipped %0b, got %0d clipped %0b",
							result_cnt, $signed(got_tap.tap), got_tap.clip,
							$signed(m_axis_tdata), m_axis_tuser));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				item_cnt++;
				tap_expect_q.push_back(predict_tap(s_axis_tdata[SAMPLE_W-1:0],
				                                   s_axis_tdata[SAMPLE_W+DELAY_W-1:SAMPLE_W]));
			end
		end
	end

	// ends the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
		    (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request or tap moved for %0d cycles", WATCHDOG_LIMIT);
			$display("** fractional_delay_line_top: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic push_item(int s, int unsigned d);
		tap_request_t r;
		r.sample = s[SAMPLE_W-1:0];
		r.delay  = d[DELAY_W-1:0];
		pending_q.push_back(r);
	endtask

	// everything sent and every tap back, then the pipeline settles
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_q.size() != 0 || s_axis_tvalid || tap_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write while idle; the shadow is set when the write is driven, before the register takes it
	task automatic set_mode(logic [MODE_W-1:0] m);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		mode_model = m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// random requests: many full-scale samples so the cubic overshoots,
	// delays mostly short, some across the whole ring
	task automatic queue_random_items(int n);
		int          k, s, sel;
		int unsigned ip, fp;
		@(negedge clk);
		for (k = 0; k < n; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 35)
				s = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
			else if (sel < 42)
				s = $urandom_range(0, 1) ? 0 : -1;
			else
				s = $urandom;
			sel = $urandom_range(0, 99);
			if (sel < 45)
				ip = $urandom_range(0, 3);
			else if (sel < 75)
				ip = $urandom_range(4, 64);
			else if (sel < 92)
				ip = $urandom_range(65, 4092);
			else
				ip = $urandom_range(4088, 4092);
			sel = $urandom_range(0, 9);
			if (sel == 0)
				fp = 0;
			else if (sel == 1)
				fp = 16'hFFFF;
			else
				fp = $urandom_range(0, 16'hFFFF);
			push_item(s, (ip << FRAC_BITS) | fp);
		end
	endtask

	initial begin
		wr_ptr_model = '0;
		mode_model   = MODE_RESET;
		foreach (ring_model[i])
			ring_model[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// linear from the reset value: extremes, zero delay, longest delay
		@(negedge clk);
		push_item(SAMPLE_MAX, 32'h0000_0000);
		push_item(SAMPLE_MIN, 32'h0000_FFFF);
		push_item(0,          32'h0001_8000);
		push_item(-1,         32'h0FFC_FFFF);
		push_item(SAMPLE_MAX, 32'h0002_0001);
		push_item(SAMPLE_MIN, 32'h0FFB_FFFF);
		push_item(1,          32'h0001_0000);
		wait_drained();

		// cubic: edge form at integer delay zero, full-scale swings that clip
		set_mode(MODE_CUBIC);
		@(negedge clk);
		push_item(SAMPLE_MIN, 32'h0000_8000);
		push_item(SAMPLE_MAX, 32'h0000_FFFF);
		push_item(SAMPLE_MAX, 32'h0001_8000);
		push_item(SAMPLE_MIN, 32'h0001_4000);
		push_item(SAMPLE_MIN, 32'h0002_C000);
		push_item(SAMPLE_MAX, 32'h0001_8000);
		push_item(SAMPLE_MAX, 32'h0000_0001);
		push_item(0,          32'h0003_FFFF);
		push_item(SAMPLE_MIN, 32'h0FFB_FFFF);
		push_item(0,          32'h0000_0000);
		wait_drained();

		// integer mode, then the unused code that acts as integer
		set_mode(MODE_INT);
		@(negedge clk);
		push_item(123456,     32'h0003_FFFF);
		push_item(-1,         32'h0FFB_FFFF);
		push_item(SAMPLE_MAX, 32'h0000_0000);
		wait_drained();
		set_mode(MODE_UNUSED);
		@(negedge clk);
		push_item(SAMPLE_MIN, 32'h0001_8000);
		push_item(42,         32'h0000_0000);
		push_item(7,          32'h0002_0000);
		wait_drained();

		// random phases across all settings
		set_mode(MODE_CUBIC);
		queue_random_items(60);
		wait_drained();

		// no idling on either side
		set_mode(MODE_LIN);
		calm = 1'b1;
		queue_random_items(60);
		wait_drained();
		calm = 1'b0;

		// output held off while requests keep coming, so the input backs up
		set_mode(MODE_CUBIC);
		queue_random_items(50);
		hold_req++;
		wait_drained();

		set_mode(MODE_INT);
		queue_random_items(60);
		wait_drained();
		set_mode(MODE_UNUSED);
		queue_random_items(40);
		wait_drained();

		// long delays reach back across the ring end
		set_mode(MODE_CUBIC);
		queue_random_items(80);
		wait_drained();
		set_mode(MODE_LIN);
		queue_random_items(60);
		wait_drained();

		$display("run covered %0d requests and %0d taps (%0d clipped) in all four modes,",
		         item_cnt, result_cnt, clip_cnt);
		$display("with a long output hold-off, delays across the ring end and %0d errors",
		         err_cnt);
		if (err_cnt == 0 && tap_expect_q.size() == 0) begin
			$display("** fractional_delay_line_top: PASSED **");
		end else begin
			$display("** fractional_delay_line_top: FAILED **");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/fdl_pkg.sv
rtl/fdl_ram.sv
rtl/fdl_ctrl.sv
rtl/fdl_dp.sv
rtl/fractional_delay_line_top.sv
rtl/fdl_checker.sv
bench/fractional_delay_line_top_tb.sv
